// File: rtl/connection_flow_table_unit_assert.svh
// Assertion macros for the connection flow table unit.
// Used by the checker module; no other dependencies.
`ifndef CONNECTION_FLOW_TABLE_UNIT_ASSERT_SVH
`define CONNECTION_FLOW_TABLE_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define CFT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication
`define CFT_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// File: rtl/cft_pkg.sv
// Package for the connection flow table: widths, codes, the command type and the hash functions.
// No dependencies.
`default_nettype none
package cft_pkg;
    localparam int Buckets = 1024;
    localparam int Slots = 1024;
    localparam int BW = $clog2(Buckets);
    localparam int SW = $clog2(Slots);
    localparam int QDEPTH = 2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_LINKED   = 2'd2;
    localparam logic [1:0] ST_UNLINKED = 2'd3;

    typedef struct packed {
        logic [1:0]    kind;
        logic [SW-1:0] handle;
        logic [31:0]   ca;
        logic [15:0]   cp;
        logic [31:0]   sa;
        logic [15:0]   sp;
    } cmd_t;

    function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        begin
            t = h + {24'd0, b};
            t = t + (t << 10);
            t = t ^ (t >> 6);
            return t;
        end
    endfunction

    function automatic logic [31:0] oaat_final(input logic [31:0] h);
        logic [31:0] t;
        begin
            t = h + (h << 3);
            t = t ^ (t >> 11);
            t = t + (t << 15);
            return t;
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/cft_front.sv
// Front end: takes commands and queues them for the table engine.
// Depends on cft_pkg.
`default_nettype none
module cft_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cft_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output cft_pkg::cmd_t      head
);
    cft_pkg::cmd_t q_reg [cft_pkg::QDEPTH];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'(cft_pkg::QDEPTH));
    assign empty = (cnt_reg == 2'd0);
    assign head  = q_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (push && !full)
            q_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && !empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

// File: rtl/cft_engine.sv
// Back end: hashes keys a byte per cycle, walks chains and updates the table.
// Depends on cft_pkg.
`default_nettype none
module cft_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire cft_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               done,
    output logic [1:0]         status,
    output logic [9:0]         found_handle,
    output logic [10:0]        entries_linked
);
    localparam int SW = cft_pkg::SW;
    localparam int BW = cft_pkg::BW;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CLEAR = 11'b00000000010,
        S_CHK   = 11'b00000000100,
        S_KEYRD = 11'b00000001000,
        S_KEYLD = 11'b00000010000,
        S_HASH  = 11'b00000100000,
        S_BRD   = 11'b00001000000,
        S_BKT   = 11'b00010000000,
        S_WALK  = 11'b00100000000,
        S_CMP   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    // memories; bucket arrays hold {valid, slot}
    logic [SW:0]   first_mem [cft_pkg::Buckets];
    logic [SW:0]   last_mem  [cft_pkg::Buckets];
    logic [SW:0]   next_mem  [cft_pkg::Slots];
    logic [95:0]   key_mem   [cft_pkg::Slots];
    logic          linked_reg [cft_pkg::Slots];

    state_t state_reg;
    logic [BW:0]   clr_reg;
    cft_pkg::cmd_t c_reg;
    logic [95:0]   key_reg;
    logic [31:0]   h_reg;
    logic [3:0]    idx_reg;
    logic [BW-1:0] b_reg;
    logic [SW:0]   cur_reg, prev_reg;
    logic [SW:0]   first_rd, last_rd, next_rd;
    logic [95:0]   key_rd;
    logic          link_rd;
    logic [1:0]    st_reg;
    logic [SW-1:0] fnd_reg;
    logic [10:0]   total_reg;
    logic          done_reg;

    logic [7:0]    kbyte;
    logic [31:0]   hfin;
    logic          hit;

    assign kbyte = key_reg[8*idx_reg +: 8];
    assign hfin  = cft_pkg::oaat_final(h_reg);
    assign hit   = (key_rd == key_reg);

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;
    assign done = done_reg;
    assign status = st_reg;
    assign found_handle = fnd_reg;
    assign entries_linked = total_reg;

    // memory ports: key read, next read, bucket reads, linked read are registered
    always_ff @(posedge clk) begin
        key_rd   <= key_mem[cur_reg[SW-1:0]];
        next_rd  <= next_mem[cur_reg[SW-1:0]];
        first_rd <= first_mem[b_reg];
        last_rd  <= last_mem[b_reg];
        link_rd  <= linked_reg[cmd.handle];
    end

    always_ff @(posedge clk) begin
        if (state_reg == S_CLEAR)
        begin
            first_mem[clr_reg[BW-1:0]] <= '0;
            last_mem[clr_reg[BW-1:0]]  <= '0;
        end
        else if (state_reg == S_BKT && c_reg.kind == cft_pkg::KIND_INSERT)
        begin
            key_mem[c_reg.handle]  <= key_reg;
            next_mem[c_reg.handle] <= '0;
            last_mem[b_reg] <= {1'b1, c_reg.handle};
            if (!first_rd[SW])
                first_mem[b_reg] <= {1'b1, c_reg.handle};
        end
        else if (state_reg == S_WALK && c_reg.kind == cft_pkg::KIND_INSERT)
        begin
            next_mem[last_rd[SW-1:0]] <= {1'b1, c_reg.handle};
        end
        else if (state_reg == S_CMP && c_reg.kind == cft_pkg::KIND_REMOVE
                 && cur_reg[SW-1:0] == c_reg.handle)
        begin
            if (prev_reg[SW])
                next_mem[prev_reg[SW-1:0]] <= next_rd;
            else
                first_mem[b_reg] <= next_rd;
            if (last_rd == {1'b1, c_reg.handle})
                last_mem[b_reg] <= prev_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (state_reg == S_BKT && c_reg.kind == cft_pkg::KIND_INSERT)
            linked_reg[c_reg.handle] <= 1'b1;
        else if (state_reg == S_CMP && c_reg.kind == cft_pkg::KIND_REMOVE
                 && cur_reg[SW-1:0] == c_reg.handle)
            linked_reg[c_reg.handle] <= 1'b0;
        else if (state_reg == S_CLEAR && clr_reg < (BW+1)'(cft_pkg::Slots))
            linked_reg[clr_reg[SW-1:0]] <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            total_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (BW+1)'(cft_pkg::Buckets - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg <= cmd;
                        key_reg <= {cmd.sp, cmd.sa, cmd.cp, cmd.ca};
                        h_reg <= '0;
                        idx_reg <= '0;
                        st_reg <= cft_pkg::ST_OK;
                        fnd_reg <= '0;
                        cur_reg <= {1'b0, cmd.handle};
                        prev_reg <= '0;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    // linked flag of the slot is valid this cycle
                    if (c_reg.kind == cft_pkg::KIND_INSERT)
                    begin
                        if (link_rd)
                        begin
                            st_reg <= cft_pkg::ST_LINKED;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_HASH;
                    end
                    else if (c_reg.kind == cft_pkg::KIND_REMOVE)
                    begin
                        if (!link_rd)
                        begin
                            st_reg <= cft_pkg::ST_UNLINKED;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_KEYRD;
                    end
                    else if (c_reg.kind == cft_pkg::KIND_SEARCH)
                    begin
                        st_reg <= cft_pkg::ST_MISS;
                        state_reg <= S_HASH;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_KEYRD: state_reg <= S_KEYLD;
                S_KEYLD:
                begin
                    key_reg <= key_rd;
                    state_reg <= S_HASH;
                end
                S_HASH:
                begin
                    if (idx_reg == 4'd12)
                    begin
                        b_reg <= hfin[BW-1:0];
                        state_reg <= S_BRD;
                    end
                    else
                    begin
                        h_reg <= cft_pkg::oaat_round(h_reg, kbyte);
                        idx_reg <= idx_reg + 4'd1;
                    end
                end
                S_BRD: state_reg <= S_BKT;
                S_BKT:
                begin
                    // bucket words are valid this cycle
                    if (c_reg.kind == cft_pkg::KIND_INSERT)
                    begin
                        total_reg <= total_reg + 11'd1;
                        if (last_rd[SW])
                            state_reg <= S_WALK;
                        else
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_reg <= first_rd;
                        prev_reg <= '0;
                        if (first_rd[SW])
                            state_reg <= S_WALK;
                        else
                        begin
                            if (c_reg.kind == cft_pkg::KIND_REMOVE)
                                total_reg <= total_reg - 11'd1;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_WALK:
                begin
                    if (c_reg.kind == cft_pkg::KIND_INSERT)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (c_reg.kind == cft_pkg::KIND_SEARCH && hit)
                    begin
                        st_reg <= cft_pkg::ST_OK;
                        fnd_reg <= cur_reg[SW-1:0];
                        state_reg <= S_DONE;
                    end
                    else if (c_reg.kind == cft_pkg::KIND_REMOVE
                             && cur_reg[SW-1:0] == c_reg.handle)
                    begin
                        total_reg <= total_reg - 11'd1;
                        state_reg <= S_DONE;
                    end
                    else if (!next_rd[SW])
                    begin
                        if (c_reg.kind == cft_pkg::KIND_REMOVE)
                            total_reg <= total_reg - 11'd1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg <= next_rd;
                        state_reg <= S_WALK;
                    end
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/connection_flow_table_unit.sv
// Top level of the connection flow table: command queue plus table engine.
// Depends on cft_pkg, cft_front and cft_engine.
//
// Usage: raise start with kind, entry_handle and the four-tuple while busy
// is low; that edge is the transfer. Each command gives one result on
// status, found_handle and entries_linked, marked by done for one cycle.
// A two-entry queue buffers commands while the engine works.
// Each command first reads the slot's registered linked flag. An insert
// or search then hashes its key in a twelve-round byte hash and reads its
// bucket; an insert links the slot behind the bucket's last entry, a
// search walks the chain memory. A remove reloads the slot's stored key
// before hashing and walks the chain to the slot. Inserts on a linked
// slot, removes on an unlinked slot and the unused kind end after that read.
// Commands run one at a time; the engine takes the next queued command
// once it is back in idle.
// After reset the engine clears its bucket tables and linked flags while
// commands queue up (busy rises when the queue is full).
// The receiver cannot stall; results are never held.
`default_nettype none
module connection_flow_table_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [9:0]  entry_handle,
    input  wire logic [31:0] client_address,
    input  wire logic [15:0] client_tcp_port,
    input  wire logic [31:0] server_address,
    input  wire logic [15:0] server_tcp_port,
    output logic             done,
    output logic [1:0]       status,
    output logic [9:0]       found_handle,
    output logic [10:0]      entries_linked
);
    cft_pkg::cmd_t in_cmd, head;
    logic full, empty, pop;

    assign in_cmd = '{kind: kind, handle: entry_handle, ca: client_address,
                      cp: client_tcp_port, sa: server_address, sp: server_tcp_port};
    assign busy = full;

    cft_front u_front (
        .clk(clk), .rst_n(rst_n), .push(start), .push_cmd(in_cmd), .full(full),
        .pop(pop), .empty(empty), .head(head)
    );

    cft_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!empty), .cmd(head), .cmd_pop(pop),
        .done(done), .status(status), .found_handle(found_handle),
        .entries_linked(entries_linked)
    );
endmodule
`default_nettype wire

// File: rtl/cft_checker.sv
// Port-level checker for the connection flow table, bound to the top level.
// Depends on connection_flow_table_unit_assert.svh and cft_pkg.
`default_nettype none
`include "connection_flow_table_unit_assert.svh"
module cft_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [9:0]  found_handle,
    input wire logic [10:0] entries_linked
);
    `CFT_ASSERT_IMP(a_found_zero, clk, rst_n, done && status != cft_pkg::ST_OK, found_handle == 10'd0)
    `CFT_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `CFT_ASSERT_IMP(a_total_range, clk, rst_n, done, entries_linked <= 11'd1024)
    `CFT_ASSERT_IMP(a_ctrl_known, clk, rst_n, 1'b1, !$isunknown(start) && !$isunknown(busy) && !$isunknown(done))
endmodule
bind connection_flow_table_unit cft_checker u_cft_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .found_handle(found_handle), .entries_linked(entries_linked)
);
`default_nettype wire

// File: tb/sv/connection_flow_table_checker.sv
`timescale 1ns / 100ps
// Checker for the connection flow table: watches command and result transfers,
// predicts each result from its own copy of the table and compares.
// Depends on cft_pkg.
module connection_flow_table_checker
    import cft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  kind,
    input  wire logic [9:0]  entry_handle,
    input  wire logic [31:0] client_address,
    input  wire logic [15:0] client_tcp_port,
    input  wire logic [31:0] server_address,
    input  wire logic [15:0] server_tcp_port,
    input  wire logic        done,
    input  wire logic [1:0]  status,
    input  wire logic [9:0]  found_handle,
    input  wire logic [10:0] entries_linked,
    output int               errors,
    output int               pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  found;
        logic [10:0] linked;
    } flow_result_t;

    typedef struct packed {
        logic [31:0] ca;
        logic [15:0] cp;
        logic [31:0] sa;
        logic [15:0] sp;
    } flow_key_t;

    flow_result_t result_q[$];
    flow_key_t    slot_key[Slots];
    bit           slot_used[Slots];
    int           chain[Buckets][$];
    logic [10:0]  total;

    function automatic logic [9:0] bucket_index(input flow_key_t k);
        logic [95:0] bytes;
        logic [31:0] h;
        bytes = {k.sp[15:8], k.sp[7:0], k.sa[31:24], k.sa[23:16], k.sa[15:8], k.sa[7:0],
                 k.cp[15:8], k.cp[7:0], k.ca[31:24], k.ca[23:16], k.ca[15:8], k.ca[7:0]};
        h = 32'd0;
        for (int i = 0; i < 12; i++)
        begin
            h = h + {24'd0, bytes[i*8 +: 8]};
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h[9:0];
    endfunction

    function automatic flow_result_t apply_command(input logic [1:0] k, input logic [9:0] hd,
                                                   input flow_key_t key);
        flow_result_t r;
        logic [9:0] b;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_INSERT:
            begin
                if (slot_used[hd])
                    r.status = ST_LINKED;
                else
                begin
                    slot_key[hd] = key;
                    slot_used[hd] = 1'b1;
                    chain[bucket_index(key)].push_back(hd);
                    total++;
                end
            end
            KIND_REMOVE:
            begin
                if (!slot_used[hd])
                    r.status = ST_UNLINKED;
                else
                begin
                    b = bucket_index(slot_key[hd]);
                    foreach (chain[b][i])
                        if (chain[b][i] == hd)
                        begin
                            chain[b].delete(i);
                            break;
                        end
                    slot_used[hd] = 1'b0;
                    total--;
                end
            end
            KIND_SEARCH:
            begin
                r.status = ST_MISS;
                b = bucket_index(key);
                foreach (chain[b][i])
                    if (slot_key[chain[b][i]] == key)
                    begin
                        r.status = ST_OK;
                        r.found = chain[b][i];
                        break;
                    end
            end
            default: ;
        endcase
        r.linked = total;
        return r;
    endfunction

    assign pending = result_q.size();

    initial
    begin
        errors = 0;
        total = '0;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
    end

    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                result_q.push_back(apply_command(kind, entry_handle,
                    {client_address, client_tcp_port, server_address, server_tcp_port}));
            if (done)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        errors++;
                    end
                    if (found_handle !== want.found)
                    begin
                        $error("found_handle: expected %0d, actual %0d", want.found,
                               found_handle);
                        errors++;
                    end
                    if (entries_linked !== want.linked)
                    begin
                        $error("entries_linked: expected %0d, actual %0d", want.linked,
                               entries_linked);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_connection_flow_table_unit.sv
`timescale 1ns / 100ps
// Testbench top for the connection flow table unit: clock, reset, command stimulus
// and verdict. Depends on cft_pkg and connection_flow_table_checker.
module tb_connection_flow_table_unit;
    import cft_pkg::*;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 930;
    localparam int CYCLE_LIMIT = 900000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [9:0]  entry_handle;
    logic [31:0] client_address;
    logic [15:0] client_tcp_port;
    logic [31:0] server_address;
    logic [15:0] server_tcp_port;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  found_handle;
    logic [10:0] entries_linked;
    int          errors;
    int          pending;
    int          idle_pct;
    int          cycles;
    logic [95:0] key_pool[32];

    connection_flow_table_unit dut (.*);
    connection_flow_table_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send(input logic [1:0] k, input logic [9:0] hd, input logic [95:0] key);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        kind <= k;
        entry_handle <= hd;
        {client_address, client_tcp_port, server_address, server_tcp_port} <= key;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    function automatic logic [95:0] random_key();
        return {$urandom, $urandom, $urandom};
    endfunction

    initial
    begin
        logic [1:0]  k;
        logic [9:0]  hd;
        logic [95:0] key;
        int          pick;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_INSERT;
        entry_handle = '0;
        {client_address, client_tcp_port, server_address, server_tcp_port} = '0;
        idle_pct = 12;
        foreach (key_pool[i])
            key_pool[i] = random_key();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        send(KIND_SEARCH, 10'd0, '0);
        send(KIND_INSERT, 10'd0, '0);
        send(KIND_INSERT, 10'd1023, '1);
        send(KIND_INSERT, 10'd0, '1);
        send(KIND_SEARCH, 10'd5, '0);
        send(KIND_SEARCH, 10'd5, '1);
        send(KIND_INSERT, 10'd7, '1);
        send(KIND_SEARCH, 10'd0, '1);
        send(KIND_REMOVE, 10'd1023, '0);
        send(KIND_SEARCH, 10'd0, '1);
        send(KIND_REMOVE, 10'd1023, '0);
        send(KIND_REMOVE, 10'd512, '1);
        send(KIND_NOP, 10'd1023, '1);
        send(KIND_INSERT, 10'd1023, key_pool[0]);
        send(KIND_INSERT, 10'd3, key_pool[0]);
        send(KIND_REMOVE, 10'd3, '0);
        send(KIND_SEARCH, 10'd0, key_pool[0]);
        send(KIND_REMOVE, 10'd7, '0);
        send(KIND_SEARCH, 10'd0, '1);
        send(KIND_REMOVE, 10'd0, '0);
        send(KIND_SEARCH, 10'd0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
                idle_pct = 82;
            else if (n == 2 * RANDOM_ITEMS / 3)
                idle_pct = 0;
            pick = $urandom_range(99);
            k = (pick < 38) ? KIND_INSERT : (pick < 62) ? KIND_REMOVE :
                (pick < 96) ? KIND_SEARCH : KIND_NOP;
            hd = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(47));
            key = ($urandom_range(9) < 6) ? key_pool[$urandom_range(31)] : random_key();
            send(k, hd, key);
        end
        @(negedge clk);
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
